FILE: sv/led_blink_controller_macros.svh
// ---------------------------------------------------------------------------
// LED blink controller assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LED_BLINK_CONTROLLER_MACROS_SVH
`define LED_BLINK_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define LBC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbc assertion failed");
`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbc assertion failed");
`else
`define LBC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/lbc_pkg.sv
// ---------------------------------------------------------------------------
// LED blink controller package
// Widths, command codes, phase encoding, shared types and saturation helpers.
// ---------------------------------------------------------------------------
package lbc_pkg;

   localparam int TIME_BITS  = 16;
   localparam int LOOP_BITS  = 16;

   localparam int CMD_W      = 3;
   localparam int TIME_W     = 16;
   localparam int LOOP_W     = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [32:0] TIME_MAX = (33'd1 << TIME_BITS) - 33'd1;
   localparam logic [32:0] LOOP_MAX = (33'd1 << LOOP_BITS) - 33'd1;

   localparam logic [0:0] REG_ACTIVE_LOW = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_ON     = 3'd1,
      CMD_OFF    = 3'd2,
      CMD_TOGGLE = 3'd3,
      CMD_BLINK  = 3'd4,
      CMD_STATUS = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_LIT  = 3'b010,
      PHASE_DARK = 3'b100
   } phase_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TIME_W-1:0] on_time;
      logic [TIME_W-1:0] off_time;
      logic [LOOP_W-1:0] loop_count;
   } req_item_type;

   typedef struct packed {
      logic pin_level;
      logic led_lit;
      logic blinking;
   } rsp_item_type;

   function automatic logic [TIME_BITS-1:0] sat_time(input logic [TIME_W-1:0] t);
      logic [32:0] wide;
      wide = 33'(t);
      if (wide > TIME_MAX) wide = TIME_MAX;
      if (wide == 33'd0) wide = 33'd1;
      return TIME_BITS'(wide);
   endfunction

   function automatic logic [LOOP_BITS-1:0] sat_loop(input logic [LOOP_W-1:0] n);
      logic [32:0] wide;
      wide = 33'(n);
      if (wide > LOOP_MAX) wide = LOOP_MAX;
      return LOOP_BITS'(wide);
   endfunction

endpackage

FILE: sv/lbc_csr.sv
// ---------------------------------------------------------------------------
// LED blink controller register port
// APB-style slave holding the polarity register.
// ---------------------------------------------------------------------------
module lbc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lbc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lbc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic                            active_low
);
   import lbc_pkg::*;

   logic       active_low_ff;
   logic       active_low_in;
   logic [0:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      active_low_in = active_low_ff;
      if (wr_en && reg_index == REG_ACTIVE_LOW) begin
         active_low_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff <= 1'b0;
      end else begin
         active_low_ff <= active_low_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_ACTIVE_LOW) begin
         prdata = CSR_DATA_W'(active_low_ff);
      end
   end

   assign active_low = active_low_ff;

endmodule

FILE: sv/lbc_core.sv
// ---------------------------------------------------------------------------
// LED blink controller core
// Blink state registers and the single-pass command update.
// ---------------------------------------------------------------------------
`include "led_blink_controller_macros.svh"

module lbc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  lbc_pkg::req_item_type item,
   input  logic                  active_low,
   output lbc_pkg::rsp_item_type result
);
   import lbc_pkg::*;

   logic                 pin_ff,     pin_in;
   phase_type            phase_ff,   phase_in;
   logic [TIME_BITS-1:0] ticks_ff,   ticks_in;
   logic [LOOP_BITS-1:0] periods_ff, periods_in;
   logic                 endless_ff, endless_in;
   logic [TIME_BITS-1:0] lit_ff,     lit_in;
   logic [TIME_BITS-1:0] dark_ff,    dark_in;
   logic [LOOP_BITS-1:0] periods_dec;

   assign periods_dec = (!endless_ff && periods_ff != '0) ?
                        periods_ff - LOOP_BITS'(1) : periods_ff;

   always_comb begin
      pin_in     = pin_ff;
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      periods_in = periods_ff;
      endless_in = endless_ff;
      lit_in     = lit_ff;
      dark_in    = dark_ff;
      case (item.cmd)
         CMD_TICK: begin
            if (phase_ff != PHASE_IDLE) begin
               if (ticks_ff <= TIME_BITS'(1)) begin
                  if (phase_ff == PHASE_LIT) begin
                     phase_in = PHASE_DARK;
                     ticks_in = dark_ff;
                     pin_in   = active_low;
                  end else begin
                     periods_in = periods_dec;
                     if (endless_ff || periods_dec != '0) begin
                        phase_in = PHASE_LIT;
                        ticks_in = lit_ff;
                        pin_in   = ~active_low;
                     end else begin
                        phase_in = PHASE_IDLE;
                        ticks_in = '0;
                     end
                  end
               end else begin
                  ticks_in = ticks_ff - TIME_BITS'(1);
               end
            end
         end
         CMD_ON: begin
            phase_in = PHASE_IDLE;
            ticks_in = '0;
            pin_in   = ~active_low;
         end
         CMD_OFF: begin
            phase_in = PHASE_IDLE;
            ticks_in = '0;
            pin_in   = active_low;
         end
         CMD_TOGGLE: begin
            phase_in = PHASE_IDLE;
            ticks_in = '0;
            pin_in   = ~pin_ff;
         end
         CMD_BLINK: begin
            lit_in  = sat_time(item.on_time);
            dark_in = sat_time(item.off_time);
            if (item.loop_count == '0) begin
               endless_in = 1'b1;
               periods_in = '0;
            end else begin
               endless_in = 1'b0;
               periods_in = sat_loop(item.loop_count);
            end
            phase_in = PHASE_LIT;
            ticks_in = sat_time(item.on_time);
            pin_in   = ~active_low;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff     <= 1'b0;
         phase_ff   <= PHASE_IDLE;
         ticks_ff   <= '0;
         periods_ff <= '0;
         endless_ff <= 1'b0;
         lit_ff     <= '0;
         dark_ff    <= '0;
      end else if (fire) begin
         pin_ff     <= pin_in;
         phase_ff   <= phase_in;
         ticks_ff   <= ticks_in;
         periods_ff <= periods_in;
         endless_ff <= endless_in;
         lit_ff     <= lit_in;
         dark_ff    <= dark_in;
      end
   end

   assign result.pin_level = pin_in;
   assign result.led_lit   = pin_in ^ active_low;
   assign result.blinking  = (phase_in != PHASE_IDLE);

   `LBC_ASSERT_IMPLY(a_idle_no_ticks, clock, reset, phase_ff == PHASE_IDLE, ticks_ff == '0)
   `LBC_ASSERT_IMPLY(a_run_has_ticks, clock, reset, phase_ff != PHASE_IDLE, ticks_ff != '0)
   `LBC_ASSERT_NEXT(a_blink_starts_lit, clock, reset, fire && item.cmd == CMD_BLINK, phase_ff == PHASE_LIT && pin_ff == ~$past(active_low))

endmodule

FILE: sv/led_blink_controller.sv
// A request transfer is captured in the input register; its response then sits in the result register.
// Throughput: one request per cycle unless responses stall; one core pass per command.
// Stalls on the response side hold the result register and back up through the input register.
// Reset (synchronous, active high) clears both registers' valids, blink state and polarity.
// ---------------------------------------------------------------------------
// LED blink controller
// Command-driven LED driver with polarity register and blink sequencer.
// ---------------------------------------------------------------------------
`include "led_blink_controller_macros.svh"

module led_blink_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lbc_pkg::CMD_W-1:0]       req_cmd,
   input  logic [lbc_pkg::TIME_W-1:0]      req_on_time,
   input  logic [lbc_pkg::TIME_W-1:0]      req_off_time,
   input  logic [lbc_pkg::LOOP_W-1:0]      req_loop_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_pin_level,
   output logic                            rsp_led_lit,
   output logic                            rsp_blinking,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lbc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lbc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import lbc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   logic         active_low;
   logic         advance;
   logic         req_xfer;

   lbc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .active_low (active_low)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.cmd        <= req_cmd;
         in_item_ff.on_time    <= req_on_time;
         in_item_ff.off_time   <= req_off_time;
         in_item_ff.loop_count <= req_loop_count;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   lbc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (in_item_ff),
      .active_low (active_low),
      .result     (core_result)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_pin_level = out_item_ff.pin_level;
   assign rsp_led_lit   = out_item_ff.led_lit;
   assign rsp_blinking  = out_item_ff.blinking;

   `LBC_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_valid_ff)
   `LBC_ASSERT_IMPLY(a_lit_matches_pol, clock, reset, out_valid_ff && !$past(advance) && $past(out_valid_ff) && $stable(active_low), rsp_led_lit == (rsp_pin_level ^ active_low))

endmodule
